### rtl/core/jtgc_pkg.sv
// Shared types, codes and helper functions of the JSON token grammar checker.
// No dependencies; compiled first.
`default_nettype none

package jtgc_pkg;

   typedef enum logic [3:0] {
      TK_LBRACE   = 4'd0,
      TK_LBRACKET = 4'd1,
      TK_RBRACE   = 4'd2,
      TK_RBRACKET = 4'd3,
      TK_STRING   = 4'd4,
      TK_NUMBER   = 4'd5,
      TK_TRUE     = 4'd6,
      TK_FALSE    = 4'd7,
      TK_NULL     = 4'd8,
      TK_COMMA    = 4'd9,
      TK_COLON    = 4'd10,
      TK_END      = 4'd11,
      TK_BAD      = 4'd12
   } token_kind_type;

   typedef enum logic [3:0] {
      PS_VALUE            = 4'd0,
      PS_EOF              = 4'd1,
      PS_END              = 4'd2,
      PS_INVALID          = 4'd3,
      PS_OBJ_KEY_OR_END   = 4'd4,
      PS_OBJ_KEY          = 4'd5,
      PS_OBJ_COLON        = 4'd6,
      PS_OBJ_VALUE        = 4'd7,
      PS_OBJ_NEXT_OR_END  = 4'd8,
      PS_ARR_VALUE_OR_END = 4'd9,
      PS_ARR_VALUE        = 4'd10,
      PS_ARR_NEXT_OR_END  = 4'd11
   } parse_state_type;

   typedef enum logic [1:0] {
      RET_EOF = 2'd0,
      RET_OBJ = 2'd1,
      RET_ARR = 2'd2
   } ret_code_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ERROR    = 2'd1,
      ST_DONE     = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CM_NONE   = 2'd0,
      CM_OBJECT = 2'd1,
      CM_ARRAY  = 2'd2
   } commit_type;

   localparam int unsigned DepthOutW = 7;

   // push/pop command for the stack row
   typedef struct packed {
      logic         push;
      logic         pop;
      ret_code_type code;
   } stack_ctl_type;

   typedef struct packed {
      status_type             status;
      commit_type             commit;
      logic                   is_key;
      logic [DepthOutW-1:0]   depth;
   } rsp_data_type;

   function automatic parse_state_type ret_to_state(input ret_code_type code);
      parse_state_type st;
      case (code)
         RET_OBJ: st = PS_OBJ_NEXT_OR_END;
         RET_ARR: st = PS_ARR_NEXT_OR_END;
         default: st = PS_EOF;
      endcase
      return st;
   endfunction

   // state after a scalar value; only called where the value is legal
   function automatic parse_state_type scalar_next(input parse_state_type st);
      parse_state_type nx;
      case (st)
         PS_VALUE:     nx = PS_EOF;
         PS_OBJ_VALUE: nx = PS_OBJ_NEXT_OR_END;
         default:      nx = PS_ARR_NEXT_OR_END;
      endcase
      return nx;
   endfunction

endpackage

`default_nettype wire

### rtl/core/jtgc_req_if.sv
// Token input channel: valid/ready handshake with token kind and restart flag.
// No dependencies.
`default_nettype none

interface jtgc_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] token_kind;
   logic       new_document;

   modport source (output valid, token_kind, new_document, input ready);
   modport sink   (input valid, token_kind, new_document, output ready);
endinterface

`default_nettype wire

### rtl/core/jtgc_rsp_if.sv
// Result channel: valid/ready handshake with status, commit, key flag and depth.
// No dependencies.
`default_nettype none

interface jtgc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [1:0] commit_kind;
   logic       is_key;
   logic [6:0] nesting_depth;

   modport source (output valid, status, commit_kind, is_key, nesting_depth, input ready);
   modport sink   (input valid, status, commit_kind, is_key, nesting_depth, output ready);
endinterface

`default_nettype wire

### rtl/core/json_token_grammar_checker.sv
// JSON token grammar checker, top level: parser, row of stack cells, result stage.
// Depends on jtgc_pkg, jtgc_req_if, jtgc_rsp_if, jtgc_stack_cell, jtgc_parser,
// jtgc_rsp_skid.
//
// Checks JSON structure from a stream of lexer token kinds, one token per item,
// and returns one result item per token: status (accepted, syntax error,
// document complete, depth overflow), nesting depth after the token, an is_key
// flag for strings taken as object keys, and a commit kind telling a value
// builder when a pending value goes into the open object or array. Closing an
// empty container commits nothing. After an error, an overflow or a complete
// document every token is rejected until an item arrives with new_document set,
// which restarts parsing before that token. Throughput is one item per clock
// while the result stage has room: the parse step (state decode plus one push
// or pop) is combinational, and the return stack is a row of MAX_DEPTH cells
// that shift down on a push and up on a pop, so its top entry is always in
// cell 0 and no memory port is involved. The result side is a two-entry stage:
// a result is registered in the output register, or in the skid register while
// the output stalls, so one more token is taken while a result waits; req ready
// is a flop and does not depend on rsp ready. Stack entries have no reset; only
// entries pushed in the current document are ever popped. nesting_depth shows
// the low seven bits of the depth when MAX_DEPTH exceeds 127.
`default_nettype none

module json_token_grammar_checker
   import jtgc_pkg::*;
#(
   parameter int unsigned MAX_DEPTH = 64
)(
   input  wire logic    clock,
   input  wire logic    reset,
   jtgc_req_if.sink     req_if,
   jtgc_rsp_if.source   rsp_if
);

   stack_ctl_type stack_ctl;
   rsp_data_type  result;
   ret_code_type  cell_code [MAX_DEPTH];
   logic          accept;
   logic          in_ready;

   assign accept       = req_if.valid && in_ready;
   assign req_if.ready = in_ready;

   jtgc_parser #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .token_kind   (req_if.token_kind),
      .new_document (req_if.new_document),
      .top_code     (cell_code[0]),
      .stack_ctl    (stack_ctl),
      .result       (result)
   );

   // stack commands only move the row on an accepted item
   stack_ctl_type cell_ctl;
   always_comb begin
      cell_ctl      = stack_ctl;
      cell_ctl.push = stack_ctl.push && accept;
      cell_ctl.pop  = stack_ctl.pop && accept;
   end

   // cell 0 is the top of stack; the new code enters there on a push
   for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
      ret_code_type above, below;
      if (i == 0) begin : g_top
         assign above = stack_ctl.code;
      end else begin : g_mid
         assign above = cell_code[i-1];
      end
      if (i == MAX_DEPTH - 1) begin : g_last
         assign below = RET_EOF;
      end else begin : g_inner
         assign below = cell_code[i+1];
      end
      jtgc_stack_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .from_above (above),
         .from_below (below),
         .code       (cell_code[i])
      );
   end

   jtgc_rsp_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_data  (result),
      .in_ready (in_ready),
      .rsp_if   (rsp_if)
   );

   // a push and a pop are never asked for together
   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !(stack_ctl.push && stack_ctl.pop))
      else $error("stack push and pop in the same cycle");

   // a push only happens for an accepted token that commits nothing
   a_push_clean: assert property (@(posedge clock) disable iff (reset)
      stack_ctl.push |-> (result.status == ST_OK && result.commit == CM_NONE && !result.is_key))
      else $error("stack push on a rejected or committing token");

   // taking a token while the output is stalled must not drop the pending result
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && rsp_if.valid && !rsp_if.ready) |=> rsp_if.valid)
      else $error("result lost while output stalled");

endmodule

`default_nettype wire

### rtl/core/jtgc_stack_cell.sv
// One entry of the shift-register return stack; shifts down on push, up on pop.
// Depends on jtgc_pkg.
`default_nettype none

module jtgc_stack_cell
   import jtgc_pkg::*;
(
   input  wire logic          clock,
   input  wire stack_ctl_type ctl,
   input  wire ret_code_type  from_above,
   input  wire ret_code_type  from_below,
   output ret_code_type       code
);

   ret_code_type code_ff, code_in;

   always_comb begin
      code_in = code_ff;
      if (ctl.push) begin
         code_in = from_above;
      end else if (ctl.pop) begin
         code_in = from_below;
      end
   end

   // payload only, contents are meaningless until pushed
   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign code = code_ff;

endmodule

`default_nettype wire

### rtl/core/jtgc_parser.sv
// Parse state machine and depth counter; decodes one token per accepted item.
// Depends on jtgc_pkg.
`default_nettype none

module jtgc_parser
   import jtgc_pkg::*;
#(
   parameter int unsigned MAX_DEPTH = 64
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic [3:0]    token_kind,
   input  wire logic          new_document,
   input  wire ret_code_type  top_code,
   output stack_ctl_type      stack_ctl,
   output rsp_data_type       result
);

   localparam int unsigned CntW = $clog2(MAX_DEPTH + 1);

   parse_state_type state_ff, state_in, cur_state;
   logic [CntW-1:0] count_ff, count_in, cur_count;
   logic [CntW+DepthOutW-1:0] depth_wide;

   token_kind_type tok;
   status_type     status;
   commit_type     commit;
   logic           is_key;
   logic           stuck, empty, full;

   assign tok       = token_kind_type'(token_kind);
   assign cur_state = new_document ? PS_VALUE : state_ff;
   assign cur_count = new_document ? '0 : count_ff;
   assign stuck     = (cur_state == PS_END) || (cur_state == PS_INVALID);
   assign empty     = (cur_count == '0);
   assign full      = (cur_count >= CntW'(MAX_DEPTH));

   // outputs: status, commit, key flag and stack command
   always_comb begin
      status         = ST_OK;
      commit         = CM_NONE;
      is_key         = 1'b0;
      stack_ctl.push = 1'b0;
      stack_ctl.pop  = 1'b0;
      stack_ctl.code = RET_EOF;
      if (stuck) begin
         status = ST_ERROR;
      end else begin
         unique case (tok) inside
            TK_LBRACE, TK_LBRACKET: begin
               case (cur_state) inside
                  PS_VALUE:                           stack_ctl.code = RET_EOF;
                  PS_OBJ_VALUE:                       stack_ctl.code = RET_OBJ;
                  PS_ARR_VALUE, PS_ARR_VALUE_OR_END:  stack_ctl.code = RET_ARR;
                  default:                            status = ST_ERROR;
               endcase
               if (status == ST_OK) begin
                  if (full) status = ST_OVERFLOW;
                  else      stack_ctl.push = 1'b1;
               end
            end
            TK_RBRACE: begin
               if ((cur_state == PS_OBJ_NEXT_OR_END || cur_state == PS_OBJ_KEY_OR_END)
                   && !empty) begin
                  stack_ctl.pop = 1'b1;
                  if (cur_state == PS_OBJ_NEXT_OR_END) commit = CM_OBJECT;
               end else begin
                  status = ST_ERROR;
               end
            end
            TK_RBRACKET: begin
               if ((cur_state == PS_ARR_NEXT_OR_END || cur_state == PS_ARR_VALUE_OR_END)
                   && !empty) begin
                  stack_ctl.pop = 1'b1;
                  if (cur_state == PS_ARR_NEXT_OR_END) commit = CM_ARRAY;
               end else begin
                  status = ST_ERROR;
               end
            end
            TK_STRING, TK_NUMBER, TK_TRUE, TK_FALSE, TK_NULL: begin
               if (tok == TK_STRING &&
                   (cur_state == PS_OBJ_KEY_OR_END || cur_state == PS_OBJ_KEY)) begin
                  is_key = 1'b1;
               end else if (!(cur_state == PS_VALUE || cur_state == PS_OBJ_VALUE ||
                              cur_state == PS_ARR_VALUE ||
                              cur_state == PS_ARR_VALUE_OR_END)) begin
                  status = ST_ERROR;
               end
            end
            TK_COMMA: begin
               if (cur_state == PS_OBJ_NEXT_OR_END)      commit = CM_OBJECT;
               else if (cur_state == PS_ARR_NEXT_OR_END) commit = CM_ARRAY;
               else                                      status = ST_ERROR;
            end
            TK_COLON: begin
               if (cur_state != PS_OBJ_COLON) status = ST_ERROR;
            end
            TK_END: begin
               if (cur_state == PS_EOF) status = ST_DONE;
               else                     status = ST_ERROR;
            end
            default: status = ST_ERROR;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = cur_state;
      if (!stuck) begin
         if (status == ST_ERROR || status == ST_OVERFLOW) begin
            state_in = PS_INVALID;
         end else begin
            unique case (tok) inside
               TK_LBRACE:               state_in = PS_OBJ_KEY_OR_END;
               TK_LBRACKET:             state_in = PS_ARR_VALUE_OR_END;
               TK_RBRACE, TK_RBRACKET:  state_in = ret_to_state(top_code);
               TK_STRING, TK_NUMBER, TK_TRUE, TK_FALSE, TK_NULL: begin
                  state_in = is_key ? PS_OBJ_COLON : scalar_next(cur_state);
               end
               TK_COMMA: begin
                  state_in = (cur_state == PS_OBJ_NEXT_OR_END) ? PS_OBJ_KEY : PS_ARR_VALUE;
               end
               TK_COLON:                state_in = PS_OBJ_VALUE;
               TK_END:                  state_in = PS_END;
               default:                 state_in = PS_INVALID;
            endcase
         end
      end
   end

   always_comb begin
      count_in = cur_count;
      if (stack_ctl.push)     count_in = cur_count + CntW'(1);
      else if (stack_ctl.pop) count_in = cur_count - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PS_VALUE;
         count_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign depth_wide    = {{DepthOutW{1'b0}}, count_in};
   assign result.status = status;
   assign result.commit = commit;
   assign result.is_key = is_key;
   assign result.depth  = depth_wide[DepthOutW-1:0];

endmodule

`default_nettype wire

### rtl/core/jtgc_rsp_skid.sv
// Two-entry result stage: output register plus skid register, registered ready.
// Depends on jtgc_pkg and jtgc_rsp_if.
`default_nettype none

module jtgc_rsp_skid
   import jtgc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire rsp_data_type  in_data,
   output logic               in_ready,
   jtgc_rsp_if.source         rsp_if
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_data_type out_data_ff, out_data_in;
   rsp_data_type skid_data_ff, skid_data_in;
   logic         take, drain;

   assign in_ready = !skid_valid_ff;
   assign take     = in_valid && in_ready;
   assign drain    = out_valid_ff && rsp_if.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (drain) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (take) begin
         if (!out_valid_ff || drain) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (drain) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.status        = out_data_ff.status;
   assign rsp_if.commit_kind   = out_data_ff.commit;
   assign rsp_if.is_key        = out_data_ff.is_key;
   assign rsp_if.nesting_depth = out_data_ff.depth;

endmodule

`default_nettype wire

### bench/tb.sv
// Testbench for json_token_grammar_checker: drives token items through the req
// channel and checks every rsp item against a predictor of the pushdown parser.
// Depends on jtgc_pkg, jtgc_req_if, jtgc_rsp_if and the RTL top level.

module tb;
   import jtgc_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int STACK_LIMIT  = 64;
   localparam int ITEM_TARGET  = 1950;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int LONG_HOLD    = 200;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;
   // widest code the 4-bit kind field can carry; 12 and up are all bad tokens
   localparam logic [3:0] KIND_FIELD_MAX = 4'hF;

   logic clock = 1'b0;
   logic reset;

   jtgc_req_if req_if();
   jtgc_rsp_if rsp_if();

   json_token_grammar_checker #(.MAX_DEPTH(STACK_LIMIT)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // ---------------------------------------------------------------------
   // Predictor state: parser state, return-code stack and its fill count
   // ---------------------------------------------------------------------
   parse_state_type parser_state = PS_VALUE;
   ret_code_type    return_codes [STACK_LIMIT];
   int              open_count = 0;

   // results owed by the block, oldest first
   rsp_data_type    pending_results [$];

   int  mismatch_count = 0;
   int  results_seen   = 0;
   int  tokens_sent    = 0;
   int  cycle_count    = 0;

   // token kinds of the document being built
   logic [3:0] doc_tokens [$];

   // idling control: steady flags switch off random gaps on either side
   bit  sender_steady     = 1'b0;
   bit  receiver_steady   = 1'b0;
   bit  long_hold_pending = 1'b0;
   int  hold_left         = 0;

   always #HALF_PERIOD clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 2);
      else if (roll < 97)
         return $urandom_range(3, 8);
      else
         return $urandom_range(15, 40);
   endfunction

   // ---------------------------------------------------------------------
   // Grammar predictor
   // ---------------------------------------------------------------------

   // Open brace or bracket: legal only where a value may start. The return
   // code remembers which context resumes once the container closes.
   function automatic status_type push_container(input parse_state_type next);
      ret_code_type code;
      case (parser_state) inside
         PS_VALUE:                          code = RET_EOF;
         PS_OBJ_VALUE:                      code = RET_OBJ;
         PS_ARR_VALUE, PS_ARR_VALUE_OR_END: code = RET_ARR;
         default:                           return ST_ERROR;
      endcase
      if (open_count >= STACK_LIMIT)
         return ST_OVERFLOW;
      return_codes[open_count] = code;
      open_count++;
      parser_state = next;
      return ST_OK;
   endfunction

   function automatic status_type pop_container();
      if (open_count == 0)
         return ST_ERROR;
      open_count--;
      case (return_codes[open_count])
         RET_OBJ: parser_state = PS_OBJ_NEXT_OR_END;
         RET_ARR: parser_state = PS_ARR_NEXT_OR_END;
         default: parser_state = PS_EOF;
      endcase
      return ST_OK;
   endfunction

   function automatic status_type take_scalar();
      case (parser_state) inside
         PS_VALUE:                          parser_state = PS_EOF;
         PS_OBJ_VALUE:                      parser_state = PS_OBJ_NEXT_OR_END;
         PS_ARR_VALUE, PS_ARR_VALUE_OR_END: parser_state = PS_ARR_NEXT_OR_END;
         default:                           return ST_ERROR;
      endcase
      return ST_OK;
   endfunction

   // One token in, one result out.
   function automatic rsp_data_type grammar_step(input logic [3:0] kind, input logic restart);
      rsp_data_type res;
      status_type   st;
      commit_type   cm;
      logic         key;
      st  = ST_OK;
      cm  = CM_NONE;
      key = 1'b0;
      if (restart) begin
         parser_state = PS_VALUE;
         open_count   = 0;
      end
      // finished or broken document: everything bounces until a restart
      if (parser_state == PS_END || parser_state == PS_INVALID) begin
         st = ST_ERROR;
      end else begin
         case (kind) inside
            TK_LBRACE:   st = push_container(PS_OBJ_KEY_OR_END);
            TK_LBRACKET: st = push_container(PS_ARR_VALUE_OR_END);
            TK_RBRACE: begin
               // an empty object closes without a commit
               if (parser_state == PS_OBJ_NEXT_OR_END)
                  cm = CM_OBJECT;
               if (parser_state == PS_OBJ_NEXT_OR_END || parser_state == PS_OBJ_KEY_OR_END)
                  st = pop_container();
               else
                  st = ST_ERROR;
            end
            TK_RBRACKET: begin
               if (parser_state == PS_ARR_NEXT_OR_END)
                  cm = CM_ARRAY;
               if (parser_state == PS_ARR_NEXT_OR_END || parser_state == PS_ARR_VALUE_OR_END)
                  st = pop_container();
               else
                  st = ST_ERROR;
            end
            TK_STRING: begin
               if (parser_state == PS_OBJ_KEY_OR_END || parser_state == PS_OBJ_KEY) begin
                  parser_state = PS_OBJ_COLON;
                  key          = 1'b1;
               end else begin
                  st = take_scalar();
               end
            end
            TK_NUMBER, TK_TRUE, TK_FALSE, TK_NULL: st = take_scalar();
            TK_COMMA: begin
               if (parser_state == PS_OBJ_NEXT_OR_END) begin
                  parser_state = PS_OBJ_KEY;
                  cm           = CM_OBJECT;
               end else if (parser_state == PS_ARR_NEXT_OR_END) begin
                  parser_state = PS_ARR_VALUE;
                  cm           = CM_ARRAY;
               end else begin
                  st = ST_ERROR;
               end
            end
            TK_COLON: begin
               if (parser_state == PS_OBJ_COLON)
                  parser_state = PS_OBJ_VALUE;
               else
                  st = ST_ERROR;
            end
            TK_END: begin
               if (parser_state == PS_EOF) begin
                  parser_state = PS_END;
                  st           = ST_DONE;
               end else begin
                  st = ST_ERROR;
               end
            end
            default: st = ST_ERROR;   // bad token and unused codes
         endcase
         // rejected token: flags cleared, depth unchanged, parser stuck
         if (st == ST_ERROR || st == ST_OVERFLOW) begin
            parser_state = PS_INVALID;
            cm           = CM_NONE;
            key          = 1'b0;
         end
      end
      res.status = st;
      res.commit = cm;
      res.is_key = key;
      res.depth  = open_count[DepthOutW-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Result check and prediction, both at the rising edge. The check goes
   // first; a result never shows up in the cycle its token is taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_and_predict
      rsp_data_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("t=%0t: result %0d with nothing expected (st=%0d cm=%0d key=%0d depth=%0d)",
                           $time, results_seen, rsp_if.status, rsp_if.commit_kind,
                           rsp_if.is_key, rsp_if.nesting_depth);
            end else begin
               want = pending_results.pop_front();
               if (rsp_if.status !== want.status || rsp_if.commit_kind !== want.commit ||
                   rsp_if.is_key !== want.is_key || rsp_if.nesting_depth !== want.depth) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"t=%0t: result %0d mismatch: exp st=%0d cm=%0d key=%0d depth=%0d,",
                               " got st=%0d cm=%0d key=%0d depth=%0d"},
                              $time, results_seen, want.status, want.commit, want.is_key,
                              want.depth, rsp_if.status, rsp_if.commit_kind, rsp_if.is_key,
                              rsp_if.nesting_depth);
               end
            end
         end
         if (req_if.valid && req_if.ready)
            pending_results.insert(pending_results.size(),
                                   grammar_step(req_if.token_kind, req_if.new_document));
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** json_token_grammar_checker: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Result receiver: random stalls, plus one long hold on request that it
   // counts down itself while the sender keeps pushing.
   // ---------------------------------------------------------------------
   initial begin : receiver
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            hold_left         = LONG_HOLD - 1;
            rsp_if.ready     <= 1'b0;
         end else begin
            hold_left = receiver_steady ? 0 : pick_gap();
            if (hold_left > 0) begin
               rsp_if.ready <= 1'b0;
               hold_left--;
            end else begin
               rsp_if.ready <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // Offer one token after a random gap and hold it until accepted. Valid
   // stays high across back-to-back items.
   task automatic send_token(input logic [3:0] kind, input logic restart);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      @(negedge clock);
      repeat (gap) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.token_kind   <= kind;
      req_if.new_document <= restart;
      do @(posedge clock); while (!req_if.ready);
      tokens_sent++;
   endtask

   // Sender pause: idle until every owed result has come back.
   task automatic wait_for_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // append one token kind to the document being built
   task automatic add_token(input logic [3:0] kind);
      doc_tokens.insert(doc_tokens.size(), kind);
   endtask

   task automatic push_scalar();
      add_token(4'($urandom_range(TK_STRING, TK_NULL)));
   endtask

   // Well-formed value of random shape, at most 'levels' containers deep.
   task automatic build_value(input int levels);
      int pick;
      int members;
      pick    = $urandom_range(0, 99);
      members = $urandom_range(0, 3);
      if (levels > 0 && pick < 25) begin
         add_token(TK_LBRACE);
         for (int i = 0; i < members; i++) begin
            if (i > 0)
               add_token(TK_COMMA);
            add_token(TK_STRING);
            add_token(TK_COLON);
            build_value(levels - 1);
         end
         add_token(TK_RBRACE);
      end else if (levels > 0 && pick < 50) begin
         add_token(TK_LBRACKET);
         for (int i = 0; i < members; i++) begin
            if (i > 0)
               add_token(TK_COMMA);
            build_value(levels - 1);
         end
         add_token(TK_RBRACKET);
      end else begin
         push_scalar();
      end
   endtask

   // Nested chain exactly 'levels' containers deep, objects and arrays mixed,
   // with an extra member here and there so closes commit as well.
   task automatic build_chain(input int levels);
      if (levels == 0) begin
         push_scalar();
      end else if ($urandom_range(0, 1)) begin
         add_token(TK_LBRACE);
         add_token(TK_STRING);
         add_token(TK_COLON);
         build_chain(levels - 1);
         if ($urandom_range(0, 1)) begin
            add_token(TK_COMMA);
            add_token(TK_STRING);
            add_token(TK_COLON);
            push_scalar();
         end
         add_token(TK_RBRACE);
      end else begin
         add_token(TK_LBRACKET);
         if ($urandom_range(0, 1)) begin
            push_scalar();
            add_token(TK_COMMA);
         end
         build_chain(levels - 1);
         add_token(TK_RBRACKET);
      end
   endtask

   // Send the built document. noise_pct swaps tokens for random codes; a rare
   // restart lands in the middle of the document.
   task automatic send_document(input logic restart, input int noise_pct);
      logic [3:0] kind;
      logic       fresh;
      for (int i = 0; i < doc_tokens.size(); i++) begin
         kind = doc_tokens[i];
         if ($urandom_range(0, 99) < noise_pct)
            kind = 4'($urandom_range(0, KIND_FIELD_MAX));
         fresh = (i == 0) ? restart : ($urandom_range(0, 199) == 0);
         send_token(kind, fresh);
      end
      doc_tokens.delete();
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Empty containers, stuck parser after completion and after an error,
   // every token kind, keys and both commit kinds, the bad code and an unused code.
   task automatic test_directed();
      send_token(TK_LBRACE,   1'b1);
      send_token(TK_RBRACE,   1'b0);   // empty object: no commit
      send_token(TK_END,      1'b0);
      send_token(TK_STRING,   1'b0);   // after completion: rejected
      send_token(TK_LBRACKET, 1'b1);
      send_token(TK_RBRACKET, 1'b0);   // empty array: no commit
      send_token(TK_END,      1'b0);
      send_token(TK_LBRACE,   1'b1);
      send_token(TK_STRING,   1'b0);   // key
      send_token(TK_COLON,    1'b0);
      send_token(TK_NUMBER,   1'b0);
      send_token(TK_COMMA,    1'b0);   // commit into object
      send_token(TK_STRING,   1'b0);
      send_token(TK_COLON,    1'b0);
      send_token(TK_LBRACKET, 1'b0);
      send_token(TK_TRUE,     1'b0);
      send_token(TK_COMMA,    1'b0);   // append to array
      send_token(TK_FALSE,    1'b0);
      send_token(TK_RBRACKET, 1'b0);   // close commits last element
      send_token(TK_RBRACE,   1'b0);   // close commits last member
      send_token(TK_END,      1'b0);
      send_token(TK_NULL,     1'b1);   // scalar document
      send_token(TK_COLON,    1'b0);   // misplaced: error
      send_token(TK_NUMBER,   1'b0);   // parser now stuck
      send_token(TK_BAD,      1'b1);
      send_token(KIND_FIELD_MAX, 1'b1);
   endtask

   // Stack full and one past it, for both container kinds, then a full-depth
   // document that unwinds back to the top level.
   task automatic test_depth_limit();
      send_token(TK_LBRACKET, 1'b1);
      repeat (STACK_LIMIT) send_token(TK_LBRACKET, 1'b0);   // last one overflows
      send_token(TK_RBRACKET, 1'b0);
      send_token(TK_LBRACKET, 1'b1);
      repeat (STACK_LIMIT - 2) send_token(TK_LBRACKET, 1'b0);
      send_token(TK_LBRACE,   1'b0);   // fills the last level
      send_token(TK_STRING,   1'b0);
      send_token(TK_COLON,    1'b0);
      send_token(TK_LBRACE,   1'b0);   // overflow from inside an object
      build_chain(STACK_LIMIT);
      add_token(TK_END);
      send_document(1'b1, 0);
   endtask

   // Receiver holds off for a long stretch while the sender streams without
   // gaps, so the result stage fills and req ready drops.
   task automatic test_backpressure();
      sender_steady     = 1'b1;
      receiver_steady   = 1'b1;
      long_hold_pending = 1'b1;
      build_chain(12);
      add_token(TK_END);
      send_document(1'b1, 0);
      wait_for_results();
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
   endtask

   // Mostly well-formed documents with random content; some noisy, some deep
   // (now and then past the limit), bursts of random tokens, and pauses.
   task automatic test_random_traffic();
      int pick;
      while (tokens_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 19) == 0) begin
            sender_steady   = ($urandom_range(0, 2) == 0);
            receiver_steady = ($urandom_range(0, 2) == 0);
         end
         if (pick < 75) begin
            build_value($urandom_range(0, 4));
            add_token(TK_END);
            send_document($urandom_range(0, 9) != 0,
                          ($urandom_range(0, 4) == 0) ? $urandom_range(2, 10) : 0);
         end else if (pick < 79) begin
            build_chain(($urandom_range(0, 5) == 0) ? $urandom_range(STACK_LIMIT - 4, STACK_LIMIT + 1)
                                                    : $urandom_range(5, 20));
            add_token(TK_END);
            send_document(1'b1, 0);
         end else if (pick < 92) begin
            repeat ($urandom_range(3, 10))
               send_token(4'($urandom_range(0, KIND_FIELD_MAX)), $urandom_range(0, 4) == 0);
         end else begin
            wait_for_results();
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.token_kind   = TK_LBRACE;
      req_if.new_document = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      wait_for_results();
      test_depth_limit();
      wait_for_results();
      test_backpressure();
      test_random_traffic();

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("** json_token_grammar_checker: PASSED **");
      else
         $display("** json_token_grammar_checker: FAILED **");
      $finish;
   end

endmodule
